// File: rtl/jsdt_pkg.sv
// Shared types and codes for the job slot dispatch table.
package jsdt_pkg;

    // Command codes
    localparam logic [2:0] CMD_LOAD   = 3'd0;
    localparam logic [2:0] CMD_CLAIM  = 3'd1;
    localparam logic [2:0] CMD_FINISH = 3'd2;
    localparam logic [2:0] CMD_QUERY  = 3'd3;
    localparam logic [2:0] CMD_RESET  = 3'd4;
    localparam logic [2:0] CMD_READ   = 3'd5;

    // Result status codes
    localparam logic [3:0] STS_OK        = 4'd0;
    localparam logic [3:0] STS_BAD_GEN   = 4'd1;
    localparam logic [3:0] STS_BUSY      = 4'd2;
    localparam logic [3:0] STS_BAD_DESC  = 4'd3;
    localparam logic [3:0] STS_OVERLAP   = 4'd4;
    localparam logic [3:0] STS_TOO_MANY  = 4'd5;
    localparam logic [3:0] STS_NONE_RDY  = 4'd6;
    localparam logic [3:0] STS_BAD_INDEX = 4'd7;
    localparam logic [3:0] STS_WRONG_ST  = 4'd8;
    localparam logic [3:0] STS_NOT_TERM  = 4'd9;
    localparam logic [3:0] STS_BAD_CMD   = 4'd10;

    // Configuration register indexes
    localparam logic [7:0] CFG_TYPE_MIN    = 8'd0;
    localparam logic [7:0] CFG_TYPE_MAX    = 8'd1;
    localparam logic [7:0] CFG_HANDLER_MIN = 8'd2;
    localparam logic [7:0] CFG_HANDLER_MAX = 8'd3;

    typedef enum logic [2:0] {
        SL_EMPTY     = 3'd0,
        SL_READY     = 3'd1,
        SL_CL_MASTER = 3'd2,
        SL_CL_SLAVE  = 3'd3,
        SL_DONE      = 3'd4,
        SL_FAILED    = 3'd5
    } t_slot_st;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_RD,
        S_CMP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] generation;
        logic [31:0] job_generation;
        logic [7:0]  job_type;
        logic [15:0] handler_id;
        logic [15:0] input_items;
        logic [31:0] span_offset;
        logic [31:0] span_length;
        logic        last;
        logic [7:0]  slot_index;
        logic        requester;
        logic        success;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [3:0]  status;
        logic [7:0]  granted_slot;
        logic [7:0]  out_type;
        logic [15:0] out_handler;
        logic [15:0] out_input_items;
        logic [31:0] out_span_offset;
        logic [31:0] out_span_length;
    } t_out_item;

    // One stored descriptor, with its precomputed span end
    typedef struct packed {
        logic [7:0]  job_type;
        logic [15:0] handler_id;
        logic [15:0] input_items;
        logic [31:0] span_offset;
        logic [31:0] span_length;
        logic [32:0] span_end;
    } t_store;

endpackage

// File: rtl/job_slot_dispatch_table.sv
// Job slot dispatch table top level: sequencer, slot states and result register.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------
//  in       | in        | i_valid / o_stall         | i_in  (t_in_item)
//  out      | out       | o_valid / i_stall         | o_out (t_out_item)
//  cfg      | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// An item passes from transfer to the result register through S_CHK, then k visits
// of the shared compare unit, then S_FIN, where k is the number of slots the unit visits
// (k <= SLOT_COUNT): load scans staged spans, claim and terminal queries scan live
// slots. Each visit is a memory read state (S_RD) followed by a compare state (S_CMP).
// Read job passes through S_RD but no compare. Reset is synchronous and empties all slots at once.
// The input stalls while an item is in work; a finished result waits in the output
// register.
module job_slot_dispatch_table #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  jsdt_pkg::t_in_item   i_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output jsdt_pkg::t_out_item  o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [CW-1:0] SLOTS = CW'(SLOT_COUNT);

    jsdt_pkg::t_state    r_state, n_state;
    jsdt_pkg::t_in_item  r_item;
    jsdt_pkg::t_out_item r_out, n_out;
    jsdt_pkg::t_slot_st  r_slot [SLOT_COUNT];
    jsdt_pkg::t_store    mem_q, wdata;

    logic [7:0]    r_type_min, r_type_max;
    logic [15:0]   r_hnd_min, r_hnd_max;
    logic [31:0]   r_bgen;
    logic [CW-1:0] r_live, r_staged;
    logic [3:0]    r_serr;
    logic [IW-1:0] r_ptr;
    logic          r_hit;
    logic [32:0]   r_end;
    logic          r_ov;

    logic          started, gen_ok, idx_ok, gen_bad_load, desc_bad, full;
    logic          load_scan, need_scan, ptr_last, cmp_hit, out_free, fin_go, mem_we;
    logic [CW-1:0] scan_n, staged_new;
    logic [3:0]    f_err, f_status;
    logic          f_store;
    jsdt_pkg::t_slot_st cur_slot, want_claim;

    // Descriptor store
    jsdt_store #(
        .DEPTH (SLOT_COUNT),
        .AW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_staged[IW-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_ptr),
        .o_rdata (mem_q)
    );

    assign wdata.job_type    = r_item.job_type;
    assign wdata.handler_id  = r_item.handler_id;
    assign wdata.input_items = r_item.input_items;
    assign wdata.span_offset = r_item.span_offset;
    assign wdata.span_length = r_item.span_length;
    assign wdata.span_end    = r_end;

    // Decode the held item against table state
    always_comb begin
        started      = (r_staged != '0) || (r_serr != jsdt_pkg::STS_OK);
        gen_ok       = (r_live != '0) && (r_item.generation != '0) &&
                       (r_item.generation == r_bgen);
        idx_ok       = 9'(r_item.slot_index) < 9'(r_live);
        gen_bad_load = (r_item.generation == '0) ||
                       (started && (r_item.generation != r_bgen));
        desc_bad     = (r_item.job_generation != r_item.generation) ||
                       (r_item.job_type < r_type_min) || (r_item.job_type > r_type_max) ||
                       (r_item.handler_id < r_hnd_min) || (r_item.handler_id > r_hnd_max) ||
                       (r_item.input_items == '0) || (r_item.span_length == '0);
        full         = r_staged >= SLOTS;
        load_scan    = (r_live == '0) && (r_serr == jsdt_pkg::STS_OK) && !gen_bad_load &&
                       !full && !desc_bad && (r_staged != '0);
        case (r_item.cmd)
            jsdt_pkg::CMD_LOAD:  need_scan = load_scan;
            jsdt_pkg::CMD_CLAIM,
            jsdt_pkg::CMD_QUERY,
            jsdt_pkg::CMD_RESET: need_scan = gen_ok;
            default:             need_scan = 1'b0;
        endcase
        scan_n   = (r_item.cmd == jsdt_pkg::CMD_LOAD) ? r_staged : r_live;
        ptr_last = (CW'(r_ptr) + CW'(1)) == scan_n;
        cur_slot = r_slot[r_ptr];
        want_claim = r_item.requester ? jsdt_pkg::SL_CL_SLAVE : jsdt_pkg::SL_CL_MASTER;
    end

    // Shared compare unit: overlap, ready or non-terminal test per visit
    always_comb begin
        case (r_item.cmd)
            jsdt_pkg::CMD_LOAD:  cmp_hit = ({1'b0, mem_q.span_offset} < r_end) &&
                                           ({1'b0, r_item.span_offset} < mem_q.span_end);
            jsdt_pkg::CMD_CLAIM: cmp_hit = cur_slot == jsdt_pkg::SL_READY;
            default:             cmp_hit = (cur_slot != jsdt_pkg::SL_DONE) &&
                                           (cur_slot != jsdt_pkg::SL_FAILED);
        endcase
    end

    // Build the result of the held item
    always_comb begin
        f_err   = jsdt_pkg::STS_OK;
        f_store = 1'b0;
        n_out   = '0;
        case (r_item.cmd)
            jsdt_pkg::CMD_LOAD: begin
                if (r_live != '0) begin
                    f_status = jsdt_pkg::STS_BUSY;
                end else begin
                    if (r_serr != jsdt_pkg::STS_OK) begin
                        f_err = r_serr;
                    end else if (gen_bad_load) begin
                        f_err = jsdt_pkg::STS_BAD_GEN;
                    end else if (full) begin
                        f_err = jsdt_pkg::STS_TOO_MANY;
                    end else if (desc_bad) begin
                        f_err = jsdt_pkg::STS_BAD_DESC;
                    end else if (r_hit) begin
                        f_err = jsdt_pkg::STS_OVERLAP;
                    end else begin
                        f_store = 1'b1;
                    end
                    f_status = f_err;
                end
            end
            jsdt_pkg::CMD_CLAIM: begin
                if (!gen_ok) begin
                    f_status = jsdt_pkg::STS_BAD_GEN;
                end else if (r_hit) begin
                    f_status = jsdt_pkg::STS_OK;
                    n_out.granted_slot = 8'(r_ptr);
                end else begin
                    f_status = jsdt_pkg::STS_NONE_RDY;
                end
            end
            jsdt_pkg::CMD_FINISH: begin
                if (!gen_ok)                f_status = jsdt_pkg::STS_BAD_GEN;
                else if (!idx_ok)           f_status = jsdt_pkg::STS_BAD_INDEX;
                else if (cur_slot != want_claim) f_status = jsdt_pkg::STS_WRONG_ST;
                else                        f_status = jsdt_pkg::STS_OK;
            end
            jsdt_pkg::CMD_QUERY,
            jsdt_pkg::CMD_RESET: begin
                if (!gen_ok)     f_status = jsdt_pkg::STS_BAD_GEN;
                else if (r_hit)  f_status = jsdt_pkg::STS_NOT_TERM;
                else             f_status = jsdt_pkg::STS_OK;
            end
            jsdt_pkg::CMD_READ: begin
                if (!gen_ok) begin
                    f_status = jsdt_pkg::STS_BAD_GEN;
                end else if (!idx_ok) begin
                    f_status = jsdt_pkg::STS_BAD_INDEX;
                end else if (cur_slot != jsdt_pkg::SL_DONE) begin
                    f_status = jsdt_pkg::STS_WRONG_ST;
                end else begin
                    f_status              = jsdt_pkg::STS_OK;
                    n_out.granted_slot    = r_item.slot_index;
                    n_out.out_type        = mem_q.job_type;
                    n_out.out_handler     = mem_q.handler_id;
                    n_out.out_input_items = mem_q.input_items;
                    n_out.out_span_offset = mem_q.span_offset;
                    n_out.out_span_length = mem_q.span_length;
                end
            end
            default: f_status = jsdt_pkg::STS_BAD_CMD;
        endcase
        n_out.ok     = f_status == jsdt_pkg::STS_OK;
        n_out.status = f_status;
        staged_new   = r_staged + CW'(f_store);
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            jsdt_pkg::S_IDLE: if (i_valid) n_state = jsdt_pkg::S_CHK;
            jsdt_pkg::S_CHK: begin
                if (need_scan || ((r_item.cmd == jsdt_pkg::CMD_READ) && gen_ok && idx_ok))
                    n_state = jsdt_pkg::S_RD;
                else
                    n_state = jsdt_pkg::S_FIN;
            end
            jsdt_pkg::S_RD: begin
                n_state = (r_item.cmd == jsdt_pkg::CMD_READ) ? jsdt_pkg::S_FIN
                                                             : jsdt_pkg::S_CMP;
            end
            jsdt_pkg::S_CMP: begin
                n_state = (cmp_hit || ptr_last) ? jsdt_pkg::S_FIN : jsdt_pkg::S_RD;
            end
            jsdt_pkg::S_FIN: if (out_free) n_state = jsdt_pkg::S_IDLE;
            default: n_state = jsdt_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        out_free    = !r_ov || !i_stall;
        o_stall     = r_state != jsdt_pkg::S_IDLE;
        fin_go      = (r_state == jsdt_pkg::S_FIN) && out_free;
        mem_we      = fin_go && (r_item.cmd == jsdt_pkg::CMD_LOAD) && (r_live == '0) &&
                      f_store;
        o_cfg_ready = 1'b1;
        o_valid     = r_ov;
        o_out       = r_out;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= jsdt_pkg::S_IDLE;
            r_type_min <= 8'd0;
            r_type_max <= 8'hFF;
            r_hnd_min  <= 16'd0;
            r_hnd_max  <= 16'hFFFF;
            r_bgen     <= '0;
            r_live     <= '0;
            r_staged   <= '0;
            r_serr     <= jsdt_pkg::STS_OK;
            r_ov       <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot[i] <= jsdt_pkg::SL_EMPTY;
            end
        end else begin
            r_state <= n_state;

            // Take configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    jsdt_pkg::CFG_TYPE_MIN:    r_type_min <= i_cfg_data[7:0];
                    jsdt_pkg::CFG_TYPE_MAX:    r_type_max <= i_cfg_data[7:0];
                    jsdt_pkg::CFG_HANDLER_MIN: r_hnd_min  <= i_cfg_data;
                    jsdt_pkg::CFG_HANDLER_MAX: r_hnd_max  <= i_cfg_data;
                    default: ;
                endcase
            end

            // Drop the result once taken
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end

            // Apply the held item's effects
            if (fin_go) begin
                r_ov <= 1'b1;
                case (r_item.cmd)
                    jsdt_pkg::CMD_LOAD: begin
                        if (r_live == '0) begin
                            if ((r_serr == jsdt_pkg::STS_OK) && !gen_bad_load && !started)
                                r_bgen <= r_item.generation;
                            if (r_item.last) begin
                                if (f_err != jsdt_pkg::STS_OK) begin
                                    r_bgen <= '0;
                                end else begin
                                    for (int i = 0; i < SLOT_COUNT; i++) begin
                                        if (CW'(i) < staged_new)
                                            r_slot[i] <= jsdt_pkg::SL_READY;
                                    end
                                    r_live <= staged_new;
                                end
                                r_staged <= '0;
                                r_serr   <= jsdt_pkg::STS_OK;
                            end else begin
                                r_staged <= staged_new;
                                r_serr   <= f_err;
                            end
                        end
                    end
                    jsdt_pkg::CMD_CLAIM: begin
                        if (gen_ok && r_hit) r_slot[r_ptr] <= want_claim;
                    end
                    jsdt_pkg::CMD_FINISH: begin
                        if (f_status == jsdt_pkg::STS_OK)
                            r_slot[r_ptr] <= r_item.success ? jsdt_pkg::SL_DONE
                                                            : jsdt_pkg::SL_FAILED;
                    end
                    jsdt_pkg::CMD_RESET: begin
                        if (f_status == jsdt_pkg::STS_OK) begin
                            for (int i = 0; i < SLOT_COUNT; i++) begin
                                r_slot[i] <= jsdt_pkg::SL_EMPTY;
                            end
                            r_live <= '0;
                            r_bgen <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Payload registers: held item, scan pointer, hit flag, span end, result
    always_ff @(posedge i_clk) begin
        if ((r_state == jsdt_pkg::S_IDLE) && i_valid) begin
            r_item <= i_in;
        end
        case (r_state)
            jsdt_pkg::S_CHK: begin
                r_hit <= 1'b0;
                r_end <= {1'b0, r_item.span_offset} + {1'b0, r_item.span_length};
                r_ptr <= need_scan ? '0 : r_item.slot_index[IW-1:0];
            end
            jsdt_pkg::S_CMP: begin
                if (cmp_hit)        r_hit <= 1'b1;
                else if (!ptr_last) r_ptr <= r_ptr + IW'(1);
            end
            default: ;
        endcase
        if (fin_go) begin
            r_out <= n_out;
        end
    end

    // Checks on table bookkeeping and sequencing
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= SLOTS)
        else $error("live count exceeds slot count");

    a_stage_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_staged != '0) |-> (r_live == '0))
        else $error("staging while a batch is live");

    a_cmp_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jsdt_pkg::S_CMP) |-> ($past(r_state) == jsdt_pkg::S_RD))
        else $error("compare without a preceding memory read");

endmodule

// File: rtl/jsdt_store.sv
// Descriptor memory: one write port, one read port with registered data.
module jsdt_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  jsdt_pkg::t_store i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output jsdt_pkg::t_store o_rdata
);

    jsdt_pkg::t_store r_mem [DEPTH];
    jsdt_pkg::t_store r_q;

    // Write and read the array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule
